// ===== src/sks_pkg.sv =====
// Shared types, character codes and register indexes for the keyed span scanner.
`timescale 1ns / 1ps

package sks_pkg;

    // Default sizing of the scanner
    localparam int MAX_KEY_CHARS_DEF = 8;
    localparam int POSITION_BITS_DEF = 32;
    localparam int DEPTH_BITS_DEF    = 16;

    // Fixed field and register widths
    localparam int CHAR_W     = 8;
    localparam int OUT_POS_W  = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int KEY_LEN_W  = 4;
    localparam int PROG_W     = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'd1;

    localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RST = 4'd3;

    // Structural characters
    localparam logic [CHAR_W-1:0] CH_OPEN   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

    // Input beat
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [OUT_POS_W-1:0] span_start;
        logic [OUT_POS_W-1:0] span_end;
        logic                 depth_overflow;
    } out_beat_t;

    // Byte that may end a key: whitespace, parens, quote or comment start
    function automatic logic is_boundary(input logic [CHAR_W-1:0] c);
        is_boundary = c inside {[8'd9:8'd13], 8'd32, 8'd133, 8'd160,
                                CH_OPEN, CH_CLOSE, CH_QUOTE, CH_SEMI};
    endfunction

endpackage

// ===== src/sexpr_keyed_span_scanner.sv =====
// Top level of the keyed s-expression span scanner.
`timescale 1ns / 1ps

// Takes one text byte per beat and one beat per clock cycle. Outside strings
// and ';' comments it looks for '(' followed by the configured key and a
// boundary byte, then follows the nesting depth until the balancing ')'; the
// start and end byte positions appear on the result channel in the cycle after
// the beat of the closing byte. The scan state logic handles every byte as it
// is accepted; s_ready drops only while a held result is not taken.
// end_of_text clears the scan state and byte position after that byte.
// Write key_chars and key_length only while no bytes are in flight.
module sexpr_keyed_span_scanner
    import sks_pkg::*;
#(
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    logic [8*MAX_KEY_CHARS-1:0] key_bytes;
    logic [KEY_LEN_W-1:0]       key_len;
    logic                       beat_fire;
    logic                       res_valid;
    out_beat_t                  res;

    assign beat_fire = s_valid && s_ready;

    sks_key_cfg #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key_bytes (key_bytes),
        .key_len   (key_len)
    );

    sks_scan_core #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS),
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (beat_fire),
        .beat      (s_data),
        .key_bytes (key_bytes),
        .key_len   (key_len),
        .res_valid (res_valid),
        .res       (res)
    );

    sks_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat_fire (beat_fire),
        .res_valid (res_valid),
        .res       (res),
        .take_ok   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== src/sks_key_cfg.sv =====
// Key configuration registers: key bytes and key length.
`timescale 1ns / 1ps

module sks_key_cfg
    import sks_pkg::*;
#(
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    output logic [8*MAX_KEY_CHARS-1:0]   key_bytes,
    output logic [KEY_LEN_W-1:0]         key_len
);

    localparam int KEY_W = 8 * MAX_KEY_CHARS;

    logic [KEY_W-1:0]     key_reg;
    logic [KEY_LEN_W-1:0] len_reg;

    // Register writes; bytes beyond the supported key length are never compared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            len_reg <= KEY_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KEY_CHARS:  key_reg <= cfg_wdata[KEY_W-1:0];
                REG_KEY_LENGTH: len_reg <= cfg_wdata[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Lengths above the supported maximum act as the maximum
    assign key_bytes = key_reg;
    assign key_len   = (len_reg > KEY_LEN_W'(MAX_KEY_CHARS)) ?
                       KEY_LEN_W'(MAX_KEY_CHARS) : len_reg;

endmodule

// ===== src/sks_scan_core.sv =====
// Per-byte scan state: string/comment tracking, key match, nesting depth.
`timescale 1ns / 1ps

module sks_scan_core
    import sks_pkg::*;
#(
    parameter int MAX_KEY_CHARS = MAX_KEY_CHARS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       beat_fire,
    input  in_beat_t                   beat,
    input  logic [8*MAX_KEY_CHARS-1:0] key_bytes,
    input  logic [KEY_LEN_W-1:0]       key_len,
    output logic                       res_valid,
    output out_beat_t                  res
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    logic                     cap_reg, cap_next;
    logic                     str_reg, str_next;
    logic                     esc_reg, esc_next;
    logic                     cmt_reg, cmt_next;
    logic [PROG_W-1:0]        prog_reg, prog_next;
    logic [DEPTH_BITS-1:0]    depth_reg, depth_next;
    logic                     sat_reg, sat_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] open_reg, open_next;

    logic                  plain;
    logic [DEPTH_BITS-1:0] depth_cnt;
    logic                  sat_cnt;
    logic [CHAR_W-1:0]     want;
    logic [PROG_W-1:0]     key_idx;
    logic                  start;
    logic                  closed;
    logic [CHAR_W-1:0]     c;

    assign c       = beat.char_code;
    assign key_idx = prog_reg - PROG_W'(1);

    // Key byte expected at the current match step
    always_comb begin
        want = '0;
        for (int i = 0; i < MAX_KEY_CHARS; i++) begin
            if (key_idx == PROG_W'(i)) begin
                want = key_bytes[8*i +: 8];
            end
        end
    end

    // String and comment tracking; plain means the byte is code
    always_comb begin
        cmt_next = cmt_reg;
        str_next = str_reg;
        esc_next = esc_reg;
        plain    = 1'b0;
        if (cmt_reg) begin
            if (c == CH_LF || c == CH_CR) cmt_next = 1'b0;
        end else if (str_reg) begin
            if (esc_reg)              esc_next = 1'b0;
            else if (c == CH_BSLASH)  esc_next = 1'b1;
            else if (c == CH_QUOTE)   str_next = 1'b0;
        end else if (c == CH_SEMI) begin
            cmt_next = 1'b1;
        end else if (c == CH_QUOTE) begin
            str_next = 1'b1;
        end else begin
            plain = 1'b1;
        end
    end

    // Depth after this byte if it is counted; saturates at the top
    always_comb begin
        depth_cnt = depth_reg;
        sat_cnt   = sat_reg;
        if (plain && c == CH_OPEN) begin
            if (depth_reg == DEPTH_MAX) sat_cnt = 1'b1;
            else                        depth_cnt = depth_reg + DEPTH_BITS'(1);
        end else if (plain && c == CH_CLOSE) begin
            if (depth_reg != '0) depth_cnt = depth_reg - DEPTH_BITS'(1);
        end
    end

    // Search / match / capture decision
    always_comb begin
        cap_next   = cap_reg;
        prog_next  = prog_reg;
        depth_next = depth_reg;
        sat_next   = sat_reg;
        open_next  = open_reg;
        start      = 1'b0;
        closed     = 1'b0;

        if (cap_reg) begin
            depth_next = depth_cnt;
            sat_next   = sat_cnt;
            closed     = (depth_cnt == '0);
        end else if (prog_reg == '0) begin
            start = plain && c == CH_OPEN;
        end else if (prog_reg <= key_len) begin
            if (c == want) begin
                depth_next = depth_cnt;
                sat_next   = sat_cnt;
                prog_next  = (depth_cnt == '0) ? '0 : prog_reg + PROG_W'(1);
            end else begin
                prog_next = '0;
                start     = plain && c == CH_OPEN;
            end
        end else begin
            // Key complete: needs a boundary byte
            prog_next = '0;
            if (is_boundary(c)) begin
                depth_next = depth_cnt;
                sat_next   = sat_cnt;
                if (depth_cnt == '0) closed = 1'b1;
                else                 cap_next = 1'b1;
            end
        end

        if (start) begin
            prog_next  = PROG_W'(1);
            open_next  = pos_reg;
            depth_next = DEPTH_BITS'(1);
            sat_next   = 1'b0;
        end

        res_valid          = closed;
        res.span_start     = OUT_POS_W'(open_reg);
        res.span_end       = OUT_POS_W'(pos_reg);
        res.depth_overflow = sat_next;

        if (closed) begin
            cap_next   = 1'b0;
            depth_next = '0;
            sat_next   = 1'b0;
        end

        pos_next = pos_reg + POSITION_BITS'(1);
    end

    // State registers; end of text returns everything to the search state
    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_fire && beat.end_of_text)) begin
            cap_reg   <= 1'b0;
            str_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            cmt_reg   <= 1'b0;
            prog_reg  <= '0;
            depth_reg <= '0;
            sat_reg   <= 1'b0;
            pos_reg   <= '0;
            open_reg  <= '0;
        end else if (beat_fire) begin
            cap_reg   <= cap_next;
            str_reg   <= str_next;
            esc_reg   <= esc_next;
            cmt_reg   <= cmt_next;
            prog_reg  <= prog_next;
            depth_reg <= depth_next;
            sat_reg   <= sat_next;
            pos_reg   <= pos_next;
            open_reg  <= open_next;
        end
    end

endmodule

// ===== src/sks_out_reg.sv =====
// Result register between the scan logic and the result channel.
`timescale 1ns / 1ps

module sks_out_reg
    import sks_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      beat_fire,
    input  logic      res_valid,
    input  out_beat_t res,
    output logic      take_ok,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic      vld_reg, vld_next;
    out_beat_t data_reg;

    // A new byte may enter when the held result is empty or leaving now
    assign take_ok = !vld_reg || m_ready;

    always_comb begin
        vld_next = vld_reg;
        if (beat_fire)    vld_next = res_valid;
        else if (m_ready) vld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= 1'b0;
        else          vld_reg <= vld_next;
    end

    always_ff @(posedge aclk) begin
        if (beat_fire && res_valid) data_reg <= res;
    end

    assign m_valid = vld_reg;
    assign m_data  = data_reg;

endmodule

// ===== tb/sv/tb_sexpr_keyed_span_scanner.sv =====
// Self-checking testbench for the keyed s-expression span scanner.
`timescale 1ns / 1ps

module tb_sexpr_keyed_span_scanner;
    import sks_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int HOLD_CYCLES      = 300;
    localparam int RAND_PHASES      = 8;
    localparam int BYTES_PER_PHASE  = 200;
    localparam logic [15:0] DEPTH_TOP = 16'hFFFF;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;

    sexpr_keyed_span_scanner u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Span predictor and the queue of spans still owed by the block
    class span_scoreboard;
        logic [63:0]          key_bytes;
        logic [KEY_LEN_W-1:0] key_len;
        bit                   in_span;
        bit                   in_string;
        bit                   esc_next;
        bit                   in_comment;
        logic [PROG_W-1:0]    progress;
        logic [15:0]          depth;
        bit                   depth_sat;
        logic [31:0]          next_pos;
        logic [31:0]          open_pos;
        out_beat_t            spans_due[$];
        int                   mismatches;
        int                   spans_seen;
        int                   bytes_seen;
        int                   overflow_spans;

        function new();
            key_bytes      = '0;
            key_len        = KEY_LENGTH_RST;
            mismatches     = 0;
            spans_seen     = 0;
            bytes_seen     = 0;
            overflow_spans = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            in_span    = 0;
            in_string  = 0;
            esc_next   = 0;
            in_comment = 0;
            progress   = '0;
            depth      = '0;
            depth_sat  = 0;
            next_pos   = '0;
            open_pos   = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_KEY_CHARS) key_bytes = data;
            else if (idx == REG_KEY_LENGTH) key_len = data[KEY_LEN_W-1:0];
        endfunction

        // Strings and comments; returns 1 when the byte is code
        function bit track_quoting(logic [7:0] c);
            if (in_comment) begin
                if (c == CH_LF || c == CH_CR) in_comment = 0;
                return 0;
            end
            if (in_string) begin
                if (esc_next) esc_next = 0;
                else if (c == CH_BSLASH) esc_next = 1;
                else if (c == CH_QUOTE) in_string = 0;
                return 0;
            end
            if (c == CH_SEMI) begin
                in_comment = 1;
                return 0;
            end
            if (c == CH_QUOTE) begin
                in_string = 1;
                return 0;
            end
            return 1;
        endfunction

        function void step_depth(logic [7:0] c);
            if (c == CH_OPEN) begin
                if (depth == DEPTH_TOP) depth_sat = 1;
                else depth++;
            end else if (c == CH_CLOSE && depth != 0) begin
                depth--;
            end
        endfunction

        function bit ends_key(logic [7:0] c);
            return c inside {[8'd9:8'd13], 8'd32, 8'd133, 8'd160,
                             CH_OPEN, CH_CLOSE, CH_QUOTE, CH_SEMI};
        endfunction

        function void open_candidate(logic [31:0] pos);
            progress  = 1;
            open_pos  = pos;
            depth     = 1;
            depth_sat = 0;
        endfunction

        // One accepted text beat: advance the scan and queue any closed span
        function void note_byte(in_beat_t b);
            logic [7:0]  c;
            logic [31:0] pos;
            logic [3:0]  klen;
            logic [2:0]  idx;
            bit          plain;
            bit          closed;
            out_beat_t   span;
            c      = b.char_code;
            pos    = next_pos;
            klen   = (key_len > 4'd8) ? 4'd8 : key_len;
            closed = 0;
            bytes_seen++;
            plain = track_quoting(c);
            if (in_span) begin
                if (plain) step_depth(c);
                if (depth == 0) closed = 1;
            end else if (progress == 0) begin
                if (plain && c == CH_OPEN) open_candidate(pos);
            end else if (progress <= klen) begin
                idx = 3'(progress - 1);
                if (c == key_bytes[8*idx +: 8]) begin
                    if (plain) step_depth(c);
                    progress++;
                    if (depth == 0) progress = 0;
                end else begin
                    progress = 0;
                    if (plain && c == CH_OPEN) open_candidate(pos);
                end
            end else begin
                progress = 0;
                if (ends_key(c)) begin
                    if (plain) step_depth(c);
                    if (depth == 0) closed = 1;
                    else in_span = 1;
                end
            end
            if (closed) begin
                span.span_start     = open_pos;
                span.span_end       = pos;
                span.depth_overflow = depth_sat;
                spans_due.push_back(span);
                in_span   = 0;
                depth     = 0;
                depth_sat = 0;
            end
            next_pos = pos + 1;
            if (b.end_of_text) clear_scan();
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_span(out_beat_t got);
            out_beat_t want;
            if (spans_due.size() == 0) begin
                flag_mismatch($sformatf("span %0d..%0d with none owed",
                                        got.span_start, got.span_end));
                return;
            end
            want = spans_due.pop_front();
            spans_seen++;
            if (want.depth_overflow) overflow_spans++;
            if (got.span_start !== want.span_start)
                flag_mismatch($sformatf("span_start %0d, want %0d",
                                        got.span_start, want.span_start));
            if (got.span_end !== want.span_end)
                flag_mismatch($sformatf("span_end %0d, want %0d",
                                        got.span_end, want.span_end));
            if (got.depth_overflow !== want.depth_overflow)
                flag_mismatch($sformatf("depth_overflow %b, want %b",
                                        got.depth_overflow, want.depth_overflow));
        endtask

        function int owed();
            return spans_due.size();
        endfunction
    endclass

    span_scoreboard sb;
    int             sender_idle_pct = 0;
    int             recv_stall_pct  = 0;
    int             hold_left       = 0;
    int             quiet_cycles    = 0;
    int             key_settings    = 0;
    logic [63:0]    cur_key;
    logic [3:0]     cur_len;
    logic [7:0]     text_q[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Beat monitor and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles = 0;
        end else begin
            if (m_valid && m_ready) sb.check_span(m_data);
            if (s_valid && s_ready) sb.note_byte(s_data);
            if (cfg_wr_en) sb.write_reg(cfg_index, cfg_wdata);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_key(logic [63:0] chars, logic [3:0] len);
        write_reg(REG_KEY_CHARS, chars);
        write_reg(REG_KEY_LENGTH, CFG_DATA_W'(len));
        cur_key = chars;
        cur_len = len;
        key_settings++;
    endtask

    // Valid stays up across back-to-back beats; it drops only for gaps
    task automatic send_beat(in_beat_t b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_text(bit mark_end);
        in_beat_t b;
        foreach (text_q[i]) begin
            b.char_code   = text_q[i];
            b.end_of_text = mark_end && (i == text_q.size() - 1);
            send_beat(b);
        end
    endtask

    // Stop sending, wait out every owed span, then the pipeline tail
    task automatic drain();
        s_valid = 1'b0;
        while (sb.owed() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic int eff_len();
        return (cur_len > 4'd8) ? 8 : int'(cur_len);
    endfunction

    function automatic void add_key_bytes(int n);
        for (int i = 0; i < n; i++) text_q.push_back(cur_key[8*i +: 8]);
    endfunction

    function automatic logic [7:0] pick_boundary();
        case ($urandom_range(11))
            0, 1, 2: return 8'd32;
            3:       return 8'($urandom_range(13, 9));
            4:       return 8'd133;
            5:       return 8'd160;
            6, 7:    return CH_OPEN;
            8:       return CH_CLOSE;
            9:       return CH_QUOTE;
            10:      return CH_SEMI;
            default: return CH_LF;
        endcase
    endfunction

    function automatic void add_space();
        case ($urandom_range(5))
            0:       text_q.push_back(8'($urandom_range(13, 9)));
            1:       text_q.push_back(($urandom_range(1) != 0) ? 8'd133 : 8'd160);
            default: text_q.push_back(8'd32);
        endcase
    endfunction

    function automatic void add_atom();
        int n;
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++)
            text_q.push_back(($urandom_range(9) < 8) ? 8'($urandom_range(122, 97))
                                                     : 8'($urandom_range(57, 48)));
    endfunction

    // String body after the opening quote, with escapes
    function automatic void add_string_tail();
        int n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: begin
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(8'($urandom_range(255)));
                end
                1:       text_q.push_back(($urandom_range(1) != 0) ? CH_OPEN : CH_CLOSE);
                2:       text_q.push_back(CH_SEMI);
                default: text_q.push_back(8'($urandom_range(122, 97)));
            endcase
        end
        text_q.push_back(CH_QUOTE);
    endfunction

    function automatic void add_comment_tail();
        int n;
        n = $urandom_range(8);
        for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(126, 32)));
        text_q.push_back(($urandom_range(1) != 0) ? CH_LF : CH_CR);
    endfunction

    function automatic void add_element(int lvl);
        case ($urandom_range(9))
            0, 1: add_atom();
            2:    add_space();
            3: begin
                text_q.push_back(CH_QUOTE);
                add_string_tail();
            end
            4: begin
                text_q.push_back(CH_SEMI);
                add_comment_tail();
            end
            5, 6, 7: begin
                if (lvl < 4) add_form(lvl + 1);
                else add_atom();
            end
            8:       text_q.push_back(8'($urandom_range(255)));
            default: add_space();
        endcase
    endfunction

    function automatic void add_body(int lvl);
        int n;
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            add_space();
            add_element(lvl);
        end
    endfunction

    // One parenthesized form: half keyed, some near misses, some plain
    function automatic void add_form(int lvl);
        int         r;
        logic [7:0] b;
        r = $urandom_range(99);
        text_q.push_back(CH_OPEN);
        if (r < 50) begin
            add_key_bytes(eff_len());
            b = pick_boundary();
            text_q.push_back(b);
            if (b == CH_CLOSE) return;
            if (b == CH_OPEN) begin
                add_body(lvl + 1);
                text_q.push_back(CH_CLOSE);
            end else if (b == CH_QUOTE) begin
                add_string_tail();
            end else if (b == CH_SEMI) begin
                add_comment_tail();
            end
        end else if (r < 60) begin
            // key cut short by a stray byte
            add_key_bytes($urandom_range(eff_len()));
            text_q.push_back(8'($urandom_range(122, 97)));
        end else if (r < 68) begin
            // whole key but no boundary after it
            add_key_bytes(eff_len());
            add_atom();
        end else begin
            add_atom();
        end
        add_body(lvl);
        text_q.push_back(CH_CLOSE);
    endfunction

    // A document of forms with some noise; a few are cut off mid-form
    function automatic void build_doc();
        int target;
        int r;
        int cut;
        text_q.delete();
        target = $urandom_range(60, 10);
        while (text_q.size() < target) begin
            r = $urandom_range(99);
            if (r < 75) begin
                add_form(0);
            end else if (r < 83) begin
                add_space();
            end else if (r < 88) begin
                text_q.push_back(CH_QUOTE);
                add_string_tail();
            end else if (r < 93) begin
                text_q.push_back(CH_SEMI);
                add_comment_tail();
            end else begin
                repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(text_q.size(), 1);
            while (text_q.size() > cut) void'(text_q.pop_back());
        end
    endfunction

    function automatic logic [63:0] letter_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++) k[8*i +: 8] = 8'($urandom_range(122, 97));
        return k;
    endfunction

    // Key bytes that are themselves structural text
    function automatic logic [63:0] mixed_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(5))
                0:       k[8*i +: 8] = CH_OPEN;
                1:       k[8*i +: 8] = CH_CLOSE;
                2:       k[8*i +: 8] = CH_QUOTE;
                3:       k[8*i +: 8] = CH_SEMI;
                4:       k[8*i +: 8] = CH_BSLASH;
                default: k[8*i +: 8] = 8'($urandom_range(122, 97));
            endcase
        end
        return k;
    endfunction

    initial begin : stimulus
        int sent;
        sb        = new();
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Key "net": immediate close, restart on mismatch, comment and string skips
        set_key(64'h0000_0000_0074_656E, 4'd3);
        text_q.delete();
        push_str("(net)(ne(net\t(a));(net)\n\"\\\"(net)\"");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text(1'b1);
        drain();

        // Key ")": the key byte itself closes the candidate, which is dropped
        set_key(64'h29, 4'd1);
        text_q.delete();
        push_str("() ()(x)");
        send_text(1'b1);
        drain();

        // Key "()": a key '(' opens no second candidate
        set_key(64'h2928, 4'd2);
        text_q.delete();
        push_str("(() x)");
        send_text(1'b1);
        drain();

        // All-ones key, length past the maximum
        set_key('1, 4'd15);
        text_q.delete();
        text_q.push_back(CH_OPEN);
        repeat (8) text_q.push_back(8'hFF);
        push_str(" )");
        send_text(1'b1);
        drain();

        // Empty key: the boundary byte follows the '(' directly
        set_key('0, 4'd0);
        text_q.delete();
        push_str("(( a) ()x(\"s\")");
        send_text(1'b1);
        drain();

        // Random documents under several keys and idle mixes
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_key(letter_key(), 4'd1);
                1:       set_key(letter_key(), 4'd8);
                2:       set_key({$urandom, $urandom}, 4'd0);
                3:       set_key({$urandom, $urandom}, 4'd15);
                4:       set_key(mixed_key(), 4'd2);
                default: set_key(letter_key(), 4'($urandom_range(8, 1)));
            endcase
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            // long output hold-off while bytes keep coming
            if (p == 0) hold_left = HOLD_CYCLES;
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                build_doc();
                send_text($urandom_range(99) < 70);
                sent += text_q.size();
            end
            drain();
        end

        $display("Covered %0d text bytes under %0d key settings with idle, stall and hold-off mixes,",
                 sb.bytes_seen, key_settings);
        $display("checking %0d spans, %0d of them with depth overflow.",
                 sb.spans_seen, sb.overflow_spans);
        if (sb.mismatches == 0 && sb.owed() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
